FILE: hdl/max_flow_bfs_augment_defines.svh
`ifndef MAX_FLOW_BFS_AUGMENT_DEFINES_SVH
`define MAX_FLOW_BFS_AUGMENT_DEFINES_SVH

// Clocked assertion, muted during reset.
`ifndef NO_ASSERTIONS
`define MF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must never hold.
`define MF_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MF_ASSERT(lbl, prop, msg)
`define MF_NEVER(lbl, cond, msg)
`endif

`endif

FILE: hdl/mf_pkg.sv
package mf_pkg;

  localparam int MF_MAX_VERTICES = 16;
  localparam int MF_CAP_BITS     = 16;
  localparam int FLOW_BITS       = 20;
  localparam int ALU_W           = 32;
  localparam logic [FLOW_BITS-1:0] FLOW_MAX = '1;
  localparam logic [4:0] VC_RESET = 5'd16;
  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_COMPUTE = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    OP_MIN,
    OP_SUB,
    OP_ADD_CAP,
    OP_ADD_FLOW
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BFS_INIT,
    ST_POP,
    ST_POP_WAIT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_BFS_END,
    ST_PM_PRED,
    ST_PM_MAT,
    ST_PM_CHK,
    ST_AU_PRED,
    ST_AU_MAT,
    ST_AU_WR1,
    ST_AU_WR2,
    ST_FLOW,
    ST_FINISH
  } state_e;

endpackage

FILE: hdl/mf_ram.sv
module mf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/mf_alu.sv
module mf_alu #(
  parameter int CAP_BITS = 16
) (
  input  mf_pkg::alu_req_t          req_i,
  output logic [mf_pkg::ALU_W-1:0]  y_o
);
  import mf_pkg::*;

  localparam logic [ALU_W:0] CapLim  = (33'd1 << CAP_BITS) - 33'd1;
  localparam logic [ALU_W:0] FlowLim = (ALU_W+1)'(FLOW_MAX);

  logic [ALU_W:0] sum;

  always_comb begin
    sum = {1'b0, req_i.a} + {1'b0, req_i.b};
    case (req_i.op)
      OP_MIN:      y_o = (req_i.b < req_i.a) ? req_i.b : req_i.a;
      OP_SUB:      y_o = req_i.a - req_i.b;
      OP_ADD_CAP:  y_o = (sum > CapLim) ? CapLim[ALU_W-1:0] : sum[ALU_W-1:0];
      OP_ADD_FLOW: y_o = (sum > FlowLim) ? FlowLim[ALU_W-1:0] : sum[ALU_W-1:0];
      default:     y_o = '0;
    endcase
  end

endmodule

FILE: hdl/max_flow_bfs_augment.sv
// Edmonds-Karp max-flow engine over a capacity matrix held in block RAM.
// Input stream: tuser carries the action (write edge, compute, clear);
// tdata carries from_vertex, to_vertex and edge_capacity. Config over APB:
// register 0 at address 0 is vertex_count (vertex 0 is source, last is sink).
// A capacity write leaves s_axis_tready high. A clear sweeps all
// MAX_VERTICES^2 matrix entries, one entry per cycle. A compute runs
// breadth-first searches with one matrix read per scanned edge, then walks
// the path twice (PM_PRED, PM_MAT, PM_CHK and AU_PRED, AU_MAT, AU_WR1,
// AU_WR2 per edge) through the shared arithmetic unit, and emits one beat
// with max_flow. The matrix has a single read port. tready is low while a
// clear or a compute runs. After reset the block runs the same clearing
// sweep before it takes a beat; config writes are taken at any time.
// The result sits in an output register: writes and clears are still taken
// while it waits; a following compute holds its result until the old beat
// is taken.
module max_flow_bfs_augment #(
  parameter int MAX_VERTICES = mf_pkg::MF_MAX_VERTICES,
  parameter int CAP_BITS     = mf_pkg::MF_CAP_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // from_vertex[3:0], to_vertex[7:4], edge_capacity[23:8]
  input  logic [1:0]  s_axis_tuser_i,  // action[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // max_flow[19:0], zero fill
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import mf_pkg::*;

  `include "max_flow_bfs_augment_defines.svh"

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int MD = MAX_VERTICES * MAX_VERTICES;
  localparam int AW = $clog2(MD);
  localparam logic [AW-1:0] ClrLast = AW'(MD - 1);
  localparam logic [CAP_BITS-1:0] CapMax = '1;
  localparam logic [32:0] CapMax33 = (33'd1 << CAP_BITS) - 33'd1;

  function automatic logic [AW-1:0] midx(input logic [VW-1:0] r, input logic [VW-1:0] c);
    return AW'(AW'(r) * AW'(MAX_VERTICES)) + AW'(c);
  endfunction

  state_e state_q, state_d;
  logic [4:0]          vc_q, vc_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [VW-1:0]       sink_q, sink_d, u_q, u_d, v_q, v_d;
  logic [CW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [MAX_VERTICES-1:0] vis_q, vis_d;
  logic [CAP_BITS-1:0] m_q, m_d;
  logic [FLOW_BITS-1:0] flow_q, flow_d, out_q, out_d;
  logic                ovalid_q, ovalid_d;

  logic                mw_en, qw_en, pw_en;
  logic [AW-1:0]       mw_addr, mr_addr;
  logic [CAP_BITS-1:0] mw_data, mr_data;
  logic [VW-1:0]       qw_addr, qw_data, qr_addr, qr_data;
  logic [VW-1:0]       pw_data, pr_addr, pr_data;
  alu_req_t            alu_req;
  logic [ALU_W-1:0]    alu_y;

  logic       s_acc;
  action_e    act;
  logic [3:0] in_from, in_to;
  logic [15:0] in_cap;
  logic [32:0] cap_ext;
  logic       cfg_wr;

  assign act     = action_e'(s_axis_tuser_i);
  assign in_from = s_axis_tdata_i[3:0];
  assign in_to   = s_axis_tdata_i[7:4];
  assign in_cap  = s_axis_tdata_i[23:8];
  assign cap_ext = 33'(in_cap);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc   = s_axis_tvalid_i && s_axis_tready_o;

  assign pready_o = 1'b1;
  assign prdata_o = 32'(vc_q);
  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i[2] == REG_VERTEX_COUNT);
  assign vc_d     = cfg_wr ? pwdata_i[4:0] : vc_q;

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = 24'(out_q);

  mf_ram #(.WIDTH(CAP_BITS), .DEPTH(MD)) u_matrix (
    .clk_i, .we_i(mw_en), .waddr_i(mw_addr), .wdata_i(mw_data),
    .raddr_i(mr_addr), .rdata_o(mr_data)
  );
  mf_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_queue (
    .clk_i, .we_i(qw_en), .waddr_i(qw_addr), .wdata_i(qw_data),
    .raddr_i(qr_addr), .rdata_o(qr_data)
  );
  mf_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_pred (
    .clk_i, .we_i(pw_en), .waddr_i(v_q), .wdata_i(pw_data),
    .raddr_i(pr_addr), .rdata_o(pr_data)
  );
  mf_alu #(.CAP_BITS(CAP_BITS)) u_alu (.req_i(alu_req), .y_o(alu_y));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:    if (clr_q == ClrLast) state_d = ST_IDLE;
      ST_IDLE: begin
        if (s_acc && act == ACT_COMPUTE) state_d = ST_BFS_INIT;
        else if (s_acc && act == ACT_CLEAR) state_d = ST_CLEAR;
      end
      ST_BFS_INIT: state_d = ST_POP;
      ST_POP:      state_d = (head_q == tail_q) ? ST_BFS_END : ST_POP_WAIT;
      ST_POP_WAIT: state_d = ST_SCAN_RD;
      ST_SCAN_RD:  state_d = ST_SCAN_CHK;
      ST_SCAN_CHK: state_d = (v_q == sink_q) ? ST_POP : ST_SCAN_RD;
      ST_BFS_END:  state_d = vis_q[sink_q] ? ST_PM_PRED : ST_FINISH;
      ST_PM_PRED:  state_d = ST_PM_MAT;
      ST_PM_MAT:   state_d = ST_PM_CHK;
      ST_PM_CHK:   state_d = (u_q == '0) ? ST_AU_PRED : ST_PM_PRED;
      ST_AU_PRED:  state_d = ST_AU_MAT;
      ST_AU_MAT:   state_d = ST_AU_WR1;
      ST_AU_WR1:   state_d = ST_AU_WR2;
      ST_AU_WR2:   state_d = (u_q == '0) ? ST_FLOW : ST_AU_PRED;
      ST_FLOW:     state_d = ST_BFS_INIT;
      ST_FINISH:   if (!ovalid_q || m_axis_tready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    clr_d = clr_q;  sink_d = sink_q; u_d = u_q; v_d = v_q;
    head_d = head_q; tail_d = tail_q; vis_d = vis_q; m_d = m_q;
    flow_d = flow_q; out_d = out_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    mw_en = 1'b0; mw_addr = midx(u_q, v_q); mw_data = '0;
    mr_addr = midx(u_q, v_q);
    qw_en = 1'b0; qw_addr = tail_q[VW-1:0]; qw_data = v_q;
    qr_addr = head_q[VW-1:0];
    pw_en = 1'b0; pw_data = u_q; pr_addr = v_q;
    alu_req = '{op: OP_MIN, a: ALU_W'(m_q), b: ALU_W'(mr_data)};
    case (state_q)
      ST_CLEAR: begin
        mw_en = 1'b1; mw_addr = clr_q; mw_data = '0;
        clr_d = clr_q + AW'(1);
      end
      ST_IDLE: begin
        clr_d = '0;
        if (s_acc && act == ACT_WRITE && int'(in_from) < MAX_VERTICES
            && int'(in_to) < MAX_VERTICES) begin
          mw_en   = 1'b1;
          mw_addr = midx(VW'(in_from), VW'(in_to));
          mw_data = (cap_ext > CapMax33) ? CapMax : CAP_BITS'(in_cap);
        end
        if (s_acc && act == ACT_COMPUTE) begin
          flow_d = '0;
          if (vc_q < 5'd2) sink_d = VW'(1);
          else if (int'(vc_q) > MAX_VERTICES) sink_d = VW'(MAX_VERTICES - 1);
          else sink_d = VW'(vc_q - 5'd1);
        end
      end
      ST_BFS_INIT: begin
        vis_d = MAX_VERTICES'(1);
        qw_en = 1'b1; qw_addr = '0; qw_data = '0;
        head_d = '0; tail_d = CW'(1);
      end
      ST_POP:      if (head_q != tail_q) head_d = head_q + CW'(1);
      ST_POP_WAIT: begin
        u_d = qr_data; v_d = '0;
      end
      ST_SCAN_RD:  mr_addr = midx(u_q, v_q);
      ST_SCAN_CHK: begin
        if (mr_data != '0 && !vis_q[v_q]) begin
          vis_d[v_q] = 1'b1;
          pw_en = 1'b1;
          qw_en = 1'b1;
          tail_d = tail_q + CW'(1);
        end
        v_d = v_q + VW'(1);
      end
      ST_BFS_END: begin
        v_d = sink_q; m_d = CapMax;
      end
      ST_PM_PRED, ST_AU_PRED: pr_addr = v_q;
      ST_PM_MAT, ST_AU_MAT: begin
        u_d = pr_data; mr_addr = midx(pr_data, v_q);
      end
      ST_PM_CHK: begin
        alu_req = '{op: OP_MIN, a: ALU_W'(m_q), b: ALU_W'(mr_data)};
        m_d = alu_y[CAP_BITS-1:0];
        v_d = (u_q == '0) ? sink_q : u_q;
      end
      ST_AU_WR1: begin
        alu_req = '{op: OP_SUB, a: ALU_W'(mr_data), b: ALU_W'(m_q)};
        mw_en = 1'b1; mw_addr = midx(u_q, v_q); mw_data = alu_y[CAP_BITS-1:0];
        mr_addr = midx(v_q, u_q);
      end
      ST_AU_WR2: begin
        alu_req = '{op: OP_ADD_CAP, a: ALU_W'(mr_data), b: ALU_W'(m_q)};
        mw_en = 1'b1; mw_addr = midx(v_q, u_q); mw_data = alu_y[CAP_BITS-1:0];
        v_d = u_q;
      end
      ST_FLOW: begin
        alu_req = '{op: OP_ADD_FLOW, a: ALU_W'(flow_q), b: ALU_W'(m_q)};
        flow_d = alu_y[FLOW_BITS-1:0];
      end
      ST_FINISH: begin
        if (!ovalid_q || m_axis_tready_i) begin
          ovalid_d = 1'b1; out_d = flow_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      vc_q     <= VC_RESET;
      clr_q    <= '0;
      vis_q    <= '0;
      ovalid_q <= 1'b0;
      flow_q   <= '0;
      head_q   <= '0;
      tail_q   <= '0;
    end else begin
      state_q  <= state_d;
      vc_q     <= vc_d;
      clr_q    <= clr_d;
      vis_q    <= vis_d;
      ovalid_q <= ovalid_d;
      flow_q   <= flow_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sink_q <= sink_d;
    u_q    <= u_d;
    v_q    <= v_d;
    m_q    <= m_d;
    out_q  <= out_d;
  end

  `MF_ASSERT(a_result_from_finish, $rose(m_axis_tvalid_o) |-> $past(state_q == ST_FINISH), "result beat raised outside finish")
  `MF_NEVER(a_queue_bound, tail_q > CW'(MAX_VERTICES), "search queue overran")
  `MF_NEVER(a_zero_bottleneck, state_q == ST_AU_WR1 && m_q == '0, "augmenting by zero")
  `MF_ASSERT(a_head_le_tail, state_q == ST_POP |-> head_q <= tail_q, "queue head passed tail")

endmodule
